/* hw/rtl/pwng_pkg.sv */
// ----------------------------------------------------------------------------
// pwng_pkg
// widths, coefficients, operation codes and helpers for the noise generator
// ----------------------------------------------------------------------------
package pwng_pkg;

	localparam int GEN_W       = 31;
	localparam int MULT_W      = 15;
	localparam int SAMPLE_W    = 24;
	localparam int GAIN_W      = 16;
	localparam int COEF_W      = 25;
	localparam int FRAC_W      = 24;
	localparam int OPA_W       = 32;
	localparam int PROD_W      = OPA_W + COEF_W;
	localparam int STATE_W     = 28;
	localparam int STATE_PRE_W = 34;
	localparam int X_W         = 25;
	localparam int SUM_W       = 32;
	localparam int NUM_POLES   = 6;
	localparam int IDX_W       = 3;
	localparam int STEP_W      = 5;
	localparam int REG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 31;

	localparam logic [GEN_W-1:0]  GEN_MOD    = '1;
	localparam logic [GEN_W-1:0]  SEED_RESET = 31'd1;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8251;

	localparam logic signed [COEF_W-1:0] PM_MULT  = 25'sd16807;
	localparam logic signed [COEF_W-1:0] PINK_DIV = 25'sd6639183;
	localparam logic signed [COEF_W-1:0] DIRECT_C = 25'sd8995943;
	localparam logic signed [COEF_W-1:0] DELAY_C  = 25'sd1944916;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE,
		REG_GAIN,
		REG_SEED
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_RAND,
		OP_GAIN,
		OP_PINK,
		OP_DIRECT,
		OP_DELAY,
		OP_POLE_A,
		OP_POLE_C
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  idx;
		logic              seed_load;
		logic [GEN_W-1:0]  seed;
		logic              mode;
		logic [GAIN_W-1:0] gain;
	} ctrl_t;

	function automatic logic signed [COEF_W-1:0] pole_a(input logic [IDX_W-1:0] i);
		logic signed [COEF_W-1:0] c;
		case (i)
			3'd0:    c = 25'sd16758090;
			3'd1:    c = 25'sd16665144;
			3'd2:    c = 25'sd16257122;
			3'd3:    c = 25'sd14537458;
			3'd4:    c = 25'sd9227469;
			3'd5:    c = -25'sd12777528;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic signed [COEF_W-1:0] pole_c(input logic [IDX_W-1:0] i);
		logic signed [COEF_W-1:0] c;
		case (i)
			3'd0:    c = 25'sd931436;
			3'd1:    c = 25'sd1259565;
			3'd2:    c = 25'sd2581208;
			3'd3:    c = 25'sd5209084;
			3'd4:    c = 25'sd8941454;
			3'd5:    c = -25'sd283501;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic signed [STATE_W-1:0] sat_state(
		input logic signed [STATE_PRE_W-1:0] v
	);
		logic signed [STATE_W-1:0] r;
		if (v[STATE_PRE_W-1:STATE_W-1] == {(STATE_PRE_W-STATE_W+1){v[STATE_PRE_W-1]}}) begin
			r = v[STATE_W-1:0];
		end else if (v[STATE_PRE_W-1]) begin
			r = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(STATE_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [SUM_W-2:0] v
	);
		logic signed [SAMPLE_W-1:0] r;
		if (v[SUM_W-2:SAMPLE_W-1] == {(SUM_W-SAMPLE_W){v[SUM_W-2]}}) begin
			r = v[SAMPLE_W-1:0];
		end else if (v[SUM_W-2]) begin
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [GEN_W-1:0] fix_seed(input logic [GEN_W-1:0] s);
		logic [GEN_W-1:0] r;
		if (s == '0 || s == GEN_MOD) begin
			r = SEED_RESET;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/pwng_tick_if.sv */
// ----------------------------------------------------------------------------
// pwng_tick_if
// request channel carrying the sample tick
// ----------------------------------------------------------------------------
interface pwng_tick_if;

	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink   (input valid, input tick, output ready);

endinterface

/* hw/rtl/pwng_noise_if.sv */
// ----------------------------------------------------------------------------
// pwng_noise_if
// result channel carrying the noise sample and the raw generator value
// ----------------------------------------------------------------------------
interface pwng_noise_if;

	logic                                 valid;
	logic                                 ready;
	logic signed [pwng_pkg::SAMPLE_W-1:0] sample;
	logic        [pwng_pkg::GEN_W-1:0]    raw_random;

	modport source (output valid, output sample, output raw_random, input ready);
	modport sink   (input valid, input sample, input raw_random, output ready);

endinterface

/* hw/rtl/pwng_mul.sv */
// ----------------------------------------------------------------------------
// pwng_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module pwng_mul (
	input  logic                                clk,
	input  logic signed [pwng_pkg::OPA_W-1:0]   opa,
	input  logic signed [pwng_pkg::COEF_W-1:0]  opb,
	output logic signed [pwng_pkg::PROD_W-1:0]  prod_s1
);
	import pwng_pkg::*;

	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
	end

endmodule

/* hw/rtl/pwng_datapath.sv */
// ----------------------------------------------------------------------------
// pwng_datapath
// operand selection, generator state, filter states and accumulation
// ----------------------------------------------------------------------------
module pwng_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pwng_pkg::ctrl_t                      ctrl,
	output logic signed [pwng_pkg::SAMPLE_W-1:0] sample,
	output logic        [pwng_pkg::GEN_W-1:0]    raw_random
);
	import pwng_pkg::*;

	logic        [GEN_W-1:0]    gen_q;
	logic signed [STATE_W-1:0]  pole_q [NUM_POLES];
	logic signed [STATE_W-1:0]  delay_q;
	op_t                        op_s1;
	logic        [IDX_W-1:0]    idx_s1;

	logic signed [SAMPLE_W-1:0] w_q;
	logic signed [X_W-1:0]      x_q;
	logic signed [PROD_W:0]     acc_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [STATE_W-1:0]  pnew_q;

	logic signed [OPA_W-1:0]    opa;
	logic signed [COEF_W-1:0]   opb;
	logic signed [PROD_W-1:0]   prod_s1;

	logic signed [SAMPLE_W-1:0] u;
	logic        [GEN_W:0]      fold1;
	logic        [GEN_W-1:0]    fold2;
	logic signed [PROD_W:0]     pole_sum;
	logic signed [STATE_W-1:0]  pole_new;
	logic signed [STATE_W-1:0]  delay_new;
	logic signed [SUM_W-1:0]    final_sum;

	// uniform value in q1.23
	assign u = {~gen_q[GEN_W-1], gen_q[GEN_W-2:GEN_W-SAMPLE_W]};

	always_comb begin
		unique case (ctrl.op)
			OP_RAND: begin
				opa = {1'b0, gen_q};
				opb = PM_MULT;
			end
			OP_GAIN: begin
				opa = OPA_W'(u);
				opb = {{(COEF_W-GAIN_W){1'b0}}, ctrl.gain};
			end
			OP_PINK: begin
				opa = OPA_W'(w_q);
				opb = PINK_DIV;
			end
			OP_DIRECT: begin
				opa = OPA_W'(x_q);
				opb = DIRECT_C;
			end
			OP_DELAY: begin
				opa = OPA_W'(x_q);
				opb = DELAY_C;
			end
			OP_POLE_A: begin
				opa = OPA_W'(pole_q[ctrl.idx]);
				opb = pole_a(ctrl.idx);
			end
			OP_POLE_C: begin
				opa = OPA_W'(x_q);
				opb = pole_c(ctrl.idx);
			end
			OP_NONE: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	pwng_mul u_mul (
		.clk     (clk),
		.opa     (opa),
		.opb     (opb),
		.prod_s1 (prod_s1)
	);

	// modulo 2^31-1 by end-around folding
	assign fold1 = {1'b0, prod_s1[GEN_W-1:0]} + (GEN_W+1)'(prod_s1[GEN_W+MULT_W-1:GEN_W]);
	assign fold2 = fold1[GEN_W-1:0] + GEN_W'(fold1[GEN_W]);

	assign pole_sum  = acc_q + (PROD_W+1)'(prod_s1);
	assign pole_new  = sat_state(pole_sum[PROD_W:FRAC_W]);
	assign delay_new = sat_state(STATE_PRE_W'($signed(prod_s1[PROD_W-1:FRAC_W])));
	assign final_sum = sum_q + SUM_W'(pnew_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q   <= SEED_RESET;
			delay_q <= '0;
			op_s1   <= OP_NONE;
			idx_s1  <= '0;
			for (int i = 0; i < NUM_POLES; i++) begin
				pole_q[i] <= '0;
			end
		end else begin
			op_s1  <= ctrl.op;
			idx_s1 <= ctrl.idx;
			if (ctrl.seed_load) begin
				gen_q <= ctrl.seed;
			end else if (op_s1 == OP_RAND) begin
				gen_q <= fold2;
			end
			if (op_s1 == OP_DELAY) begin
				delay_q <= delay_new;
			end
			if (op_s1 == OP_POLE_C) begin
				pole_q[idx_s1] <= pole_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op_s1)
			OP_GAIN: begin
				w_q <= prod_s1[GAIN_W+SAMPLE_W-1:GAIN_W];
			end
			OP_PINK: begin
				x_q <= {prod_s1[FRAC_W+SAMPLE_W-1:FRAC_W], 1'b0};
			end
			OP_DIRECT: begin
				sum_q  <= SUM_W'(delay_q) + SUM_W'($signed(prod_s1[FRAC_W+X_W-1:FRAC_W]));
				pnew_q <= '0;
			end
			OP_POLE_A: begin
				acc_q <= (PROD_W+1)'(prod_s1);
			end
			OP_POLE_C: begin
				sum_q  <= sum_q + SUM_W'(pnew_q);
				pnew_q <= pole_new;
			end
			default: begin
			end
		endcase
	end

	assign sample     = ctrl.mode ? sat_sample(final_sum[SUM_W-1:1]) : w_q;
	assign raw_random = gen_q;

endmodule

/* hw/rtl/pink_white_noise_generator_core.sv */
// ----------------------------------------------------------------------------
// pink_white_noise_generator_core
// white or pink noise samples from a 31-bit multiplicative generator
// ----------------------------------------------------------------------------
// a new tick is taken only in the idle state, after the previous sample has
// been loaded into the result register, which waits while the output stalls;
// the single shared multiplier forms all 17 products of a pink sample
// a zero tick is taken and produces no result
// reset: white mode, level 8251, generator state 1, filter states cleared
module pink_white_noise_generator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	pwng_tick_if.sink                            req,
	pwng_noise_if.source                         res,
	input  logic                                 wr_en,
	input  logic [pwng_pkg::REG_IDX_W-1:0]       wr_index,
	input  logic [pwng_pkg::CFG_DATA_W-1:0]      wr_data
);
	import pwng_pkg::*;

	localparam logic [STEP_W-1:0] STEP_RAND       = 5'd0;
	localparam logic [STEP_W-1:0] STEP_GAIN       = 5'd2;
	localparam logic [STEP_W-1:0] STEP_PINK       = 5'd4;
	localparam logic [STEP_W-1:0] STEP_DIRECT     = 5'd6;
	localparam logic [STEP_W-1:0] STEP_DELAY      = 5'd7;
	localparam logic [STEP_W-1:0] STEP_POLE_FIRST = 5'd8;
	localparam logic [STEP_W-1:0] STEP_POLE_LAST  = 5'd19;
	localparam logic [STEP_W-1:0] STEP_WHITE_DONE = 5'd4;
	localparam logic [STEP_W-1:0] STEP_PINK_DONE  = 5'd21;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                     state_q;
	logic [STEP_W-1:0]          step_q;
	logic                       res_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [GEN_W-1:0]           raw_q;
	logic                       mode_q;
	logic [GAIN_W-1:0]          gain_q;

	ctrl_t                      ctrl;
	logic signed [SAMPLE_W-1:0] dp_sample;
	logic [GEN_W-1:0]           dp_raw;
	logic                       start;
	logic                       last;
	logic                       can_load;
	logic [STEP_W-1:0]          pole_step;

	function automatic op_t step_op(input logic [STEP_W-1:0] s);
		op_t o;
		priority if (s == STEP_RAND) begin
			o = OP_RAND;
		end else if (s == STEP_GAIN) begin
			o = OP_GAIN;
		end else if (s == STEP_PINK) begin
			o = OP_PINK;
		end else if (s == STEP_DIRECT) begin
			o = OP_DIRECT;
		end else if (s == STEP_DELAY) begin
			o = OP_DELAY;
		end else if (s >= STEP_POLE_FIRST && s <= STEP_POLE_LAST) begin
			o = s[0] ? OP_POLE_C : OP_POLE_A;
		end else begin
			o = OP_NONE;
		end
		return o;
	endfunction

	assign req.ready = (state_q == ST_IDLE);
	assign start     = req.valid && req.ready && req.tick;
	assign last      = mode_q ? (step_q == STEP_PINK_DONE) : (step_q == STEP_WHITE_DONE);
	assign can_load  = !res_valid_q || res.ready;
	assign pole_step = step_q - STEP_POLE_FIRST;

	always_comb begin
		ctrl.op        = (state_q == ST_RUN && !last) ? step_op(step_q) : OP_NONE;
		ctrl.idx       = pole_step[IDX_W:1];
		ctrl.seed_load = wr_en && (wr_index == REG_SEED);
		ctrl.seed      = fix_seed(wr_data[GEN_W-1:0]);
		ctrl.mode      = mode_q;
		ctrl.gain      = gain_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			gain_q <= GAIN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_MODE: mode_q <= wr_data[0];
				REG_GAIN: gain_q <= wr_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pwng_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample     (dp_sample),
		.raw_random (dp_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
			sample_q    <= '0;
			raw_q       <= '0;
		end else begin
			if (state_q == ST_RUN && last && can_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (last) begin
						if (can_load) begin
							sample_q    <= dp_sample;
							raw_q       <= dp_raw;
							state_q     <= ST_IDLE;
							step_q      <= '0;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
			endcase
		end
	end

	assign res.valid      = res_valid_q;
	assign res.sample     = sample_q;
	assign res.raw_random = raw_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> step_q <= STEP_PINK_DONE)
		else $error("step counter past final step");

	a_white_short: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && !mode_q |-> step_q <= STEP_WHITE_DONE)
		else $error("white sample ran into filter steps");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> state_q == ST_RUN && step_q == '0)
		else $error("sequence did not start at first step");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_RUN && last))
		else $error("result raised outside final step");

endmodule

/* sim/pwng_sample_checker.sv */
// ----------------------------------------------------------------------------
// pwng_sample_checker
// watches the tick and noise channels and the register port, keeps its own
// generator, level and filter state, and compares each noise result in
// order against the predicted sample and raw generator value
// ----------------------------------------------------------------------------
module pwng_sample_checker
	import pwng_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	pwng_tick_if                  req,
	pwng_noise_if                 res,
	input  logic                  wr_en,
	input  logic [REG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output int                    mismatches,
	output int                    samples_waiting,
	output int                    samples_checked,
	output int                    pink_predicted
);

	localparam longint PM_FACTOR   = 16807;
	localparam longint PINK_SCALE  = 6639183;
	localparam longint DIRECT_GAIN = 8995943;
	localparam longint DELAY_GAIN  = 1944916;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [GEN_W-1:0]    raw_random;
	} noise_t;

	logic             pink_mode;
	logic [GAIN_W-1:0] level;
	logic [GEN_W-1:0]  gen_value;
	longint            pole_acc [NUM_POLES];
	longint            delay_acc;
	noise_t            expected_samples [$];
	noise_t            got;
	noise_t            want;

	function automatic longint pole_feedback(input int i);
		longint k;
		case (i)
			0:       k = 16758090;
			1:       k = 16665144;
			2:       k = 16257122;
			3:       k = 14537458;
			4:       k = 9227469;
			default: k = -12777528;
		endcase
		return k;
	endfunction

	function automatic longint pole_input(input int i);
		longint k;
		case (i)
			0:       k = 931436;
			1:       k = 1259565;
			2:       k = 2581208;
			3:       k = 5209084;
			4:       k = 8941454;
			default: k = -283501;
		endcase
		return k;
	endfunction

	function automatic longint clamp(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic logic [GEN_W-1:0] park_miller(input logic [GEN_W-1:0] s);
		logic [63:0] p;
		p = 64'(s) * 64'(PM_FACTOR);
		p = (p & 64'h7FFF_FFFF) + (p >> 31);
		p = (p & 64'h7FFF_FFFF) + (p >> 31);
		return p[GEN_W-1:0];
	endfunction

	// advances the generator state, and in pink mode the filter state, and returns the sample this tick makes
	function automatic noise_t next_expected_sample();
		noise_t n;
		longint u;
		longint w;
		longint x;
		longint acc;
		longint s;
		gen_value = park_miller(gen_value);
		u = longint'(gen_value >> 7) - (longint'(1) <<< 23);
		w = (u * longint'(level)) >>> 16;
		if (!pink_mode) begin
			s = clamp(w, SAMPLE_W);
		end else begin
			x = 2 * ((w * PINK_SCALE) >>> 24);
			acc = 0;
			for (int i = 0; i < NUM_POLES; i++) begin
				pole_acc[i] = clamp((pole_feedback(i) * pole_acc[i] + pole_input(i) * x) >>> 24,
					STATE_W);
				acc += pole_acc[i];
			end
			acc += delay_acc;
			acc += (DIRECT_GAIN * x) >>> 24;
			s = clamp(acc >>> 1, SAMPLE_W);
			delay_acc = clamp((DELAY_GAIN * x) >>> 24, STATE_W);
		end
		n.sample     = s[SAMPLE_W-1:0];
		n.raw_random = gen_value;
		return n;
	endfunction

	task automatic note_failure(input string what);
		if (mismatches < 10) begin
			$display("%s", what);
		end
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pink_mode = 1'b0;
			level     = GAIN_RESET;
			gen_value = SEED_RESET;
			for (int i = 0; i < NUM_POLES; i++) begin
				pole_acc[i] = 0;
			end
			delay_acc = 0;
			expected_samples.delete();
			mismatches      = 0;
			samples_checked = 0;
			pink_predicted  = 0;
		end else begin
			if (res.valid && res.ready) begin
				got.sample     = res.sample;
				got.raw_random = res.raw_random;
				if (expected_samples.size() == 0) begin
					note_failure($sformatf("unexpected sample %0d raw %h",
						$signed(got.sample), got.raw_random));
				end else begin
					want = expected_samples.pop_front();
					samples_checked++;
					if (got.sample !== want.sample || got.raw_random !== want.raw_random) begin
						note_failure($sformatf(
							"mismatch: sample expected %0d got %0d, raw expected %h got %h",
							$signed(want.sample), $signed(got.sample),
							want.raw_random, got.raw_random));
					end
				end
			end
			if (wr_en) begin
				case (wr_index)
					REG_MODE: pink_mode = wr_data[0];
					REG_GAIN: level = wr_data[GAIN_W-1:0];
					REG_SEED: begin
						if (wr_data == '0 || wr_data == '1) begin
							gen_value = SEED_RESET;
						end else begin
							gen_value = wr_data;
						end
					end
					default: ;
				endcase
			end
			if (req.valid && req.ready && req.tick) begin
				if (pink_mode) begin
					pink_predicted++;
				end
				expected_samples.push_back(next_expected_sample());
			end
		end
		samples_waiting = expected_samples.size();
	end

endmodule

/* sim/tb_pink_white_noise_generator_core.sv */
// ----------------------------------------------------------------------------
// tb_pink_white_noise_generator_core
// drives sample ticks in random bursts through a set of level, seed and
// mode settings, stalls the result side, and lets the sample checker judge
// ----------------------------------------------------------------------------
module tb_pink_white_noise_generator_core;
	import pwng_pkg::*;

	localparam int                     IDLE_LIMIT      = 2000;
	localparam int                     SETTLE_CYCLES   = 30;
	localparam int                     PHASES          = 10;
	localparam int                     TICKS_PER_PHASE = 46;
	localparam logic [REG_IDX_W-1:0]   REG_UNUSED      = 2'd3;
	localparam logic [CFG_DATA_W-1:0]  SEED_TOP        = 31'h7FFF_FFFE;

	typedef enum int {
		FLOW_OPEN,
		FLOW_PATCHY,
		FLOW_CHOKED
	} flow_t;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en;
	logic [REG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	int mismatches;
	int samples_waiting;
	int samples_checked;
	int pink_predicted;
	int idle_cycles   = 0;
	int burst_left    = 0;
	int requests_sent = 0;
	int zero_ticks    = 0;
	int reg_writes    = 0;

	pwng_tick_if  tick_ch ();
	pwng_noise_if noise_ch ();

	pink_white_noise_generator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (tick_ch),
		.res      (noise_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	pwng_sample_checker sample_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (tick_ch),
		.res             (noise_ch),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.mismatches      (mismatches),
		.samples_waiting (samples_waiting),
		.samples_checked (samples_checked),
		.pink_predicted  (pink_predicted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((tick_ch.valid && tick_ch.ready) || (noise_ch.valid && noise_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side stalls in segments: open, patchy or mostly closed
	initial begin : receiver
		flow_t flow;
		int    flow_left;
		noise_ch.ready = 1'b0;
		flow      = FLOW_OPEN;
		flow_left = 0;
		forever begin
			@(negedge clk);
			if (flow_left == 0) begin
				flow      = flow_t'($urandom_range(FLOW_OPEN, FLOW_CHOKED));
				flow_left = $urandom_range(10, 60);
			end
			flow_left--;
			case (flow)
				FLOW_OPEN:   noise_ch.ready <= 1'b1;
				FLOW_PATCHY: noise_ch.ready <= ($urandom_range(0, 1) == 1);
				default:     noise_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic send_tick(input logic t);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				tick_ch.valid <= 1'b0;
				tick_ch.tick  <= 1'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		tick_ch.valid <= 1'b1;
		tick_ch.tick  <= t;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		requests_sent++;
		if (!t) begin
			zero_ticks++;
		end
	endtask

	// hold the request side until every sample has come back
	task automatic wait_drained(input int extra);
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (samples_waiting != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		reg_writes++;
	endtask

	initial begin : stimulus
		int                ones;
		logic [GAIN_W-1:0] gain;
		logic [GEN_W-1:0]  seed;
		tick_ch.valid = 1'b0;
		tick_ch.tick  = 1'b0;
		wr_en         = 1'b0;
		wr_index      = REG_MODE;
		wr_data       = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings, with an empty tick in between
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_GAIN, '1);
		write_reg(REG_SEED, SEED_TOP);
		repeat (3) send_tick(1'b1);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_GAIN, '0);
		repeat (2) send_tick(1'b1);
		// degenerate seeds fall back to one
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_SEED, '0);
		repeat (2) send_tick(1'b1);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_SEED, '1);
		repeat (2) send_tick(1'b1);
		// pink at full level
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_MODE, 31'd1);
		write_reg(REG_GAIN, 31'h0000_FFFF);
		write_reg(REG_SEED, 31'd1);
		repeat (6) send_tick(1'b1);
		// write to an index with no register behind it
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_UNUSED, '1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		wait_drained(SETTLE_CYCLES);
		write_reg(REG_MODE, 31'h7FFF_FFFE);
		send_tick(1'b1);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained(SETTLE_CYCLES);
			write_reg(REG_MODE, {30'($urandom), ($urandom_range(0, 2) != 0)});
			case ($urandom_range(0, 4))
				0:       gain = '0;
				1:       gain = '1;
				default: gain = 16'($urandom);
			endcase
			write_reg(REG_GAIN, {15'($urandom), gain});
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 5))
					0:       seed = '0;
					1:       seed = '1;
					2:       seed = 31'd1;
					3:       seed = SEED_TOP;
					default: seed = 31'($urandom);
				endcase
				write_reg(REG_SEED, seed);
			end
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_UNUSED, 31'($urandom));
			end
			ones = 0;
			while (ones < TICKS_PER_PHASE) begin
				if ($urandom_range(0, 39) == 0) begin
					wait_drained(0);
				end
				if ($urandom_range(0, 7) == 0) begin
					send_tick(1'b0);
				end else begin
					send_tick(1'b1);
					ones++;
				end
			end
		end
		wait_drained(SETTLE_CYCLES);

		$display("run covered %0d requests (%0d empty ticks) over %0d register writes",
			requests_sent, zero_ticks, reg_writes);
		$display("%0d samples compared, %0d of them through the pink filter",
			samples_checked, pink_predicted);
		if (mismatches == 0 && samples_waiting == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
